// ----- rtl/q24_pkg.sv -----
package q24_pkg;

  localparam int WordWidth = 32;
  localparam int FracBits = 8;
  localparam int NumWidth = WordWidth + FracBits;
  localparam int DivCells = NumWidth;

  localparam logic [3:0] OpAdd = 4'd0;
  localparam logic [3:0] OpSub = 4'd1;
  localparam logic [3:0] OpMul = 4'd2;
  localparam logic [3:0] OpDiv = 4'd3;
  localparam logic [3:0] OpGt = 4'd4;
  localparam logic [3:0] OpLt = 4'd5;
  localparam logic [3:0] OpGe = 4'd6;
  localparam logic [3:0] OpLe = 4'd7;
  localparam logic [3:0] OpEq = 4'd8;
  localparam logic [3:0] OpNe = 4'd9;
  localparam logic [3:0] OpMin = 4'd10;
  localparam logic [3:0] OpMax = 4'd11;
  localparam logic [3:0] OpInc = 4'd12;
  localparam logic [3:0] OpDec = 4'd13;
  localparam logic [3:0] OpFromInt = 4'd14;
  localparam logic [3:0] OpToInt = 4'd15;

  typedef struct packed {
    logic [WordWidth-1:0] res;
    logic cmp;
    logic dz;
    logic is_mul;
    logic is_div;
    logic neg;
  } side_t;

  typedef struct packed {
    logic valid;
    side_t side;
    logic [NumWidth-1:0] rem;
    logic [NumWidth-1:0] num;
    logic [WordWidth-1:0] den;
    logic [2*WordWidth-1:0] prod;
  } lane_t;

endpackage

// ----- rtl/q24_cell.sv -----
module q24_cell (
  input  logic clk,
  input  logic rst,
  input  logic stall,
  input  q24_pkg::lane_t lane_in,
  output q24_pkg::lane_t lane_out
);

  logic [q24_pkg::NumWidth:0] trial;
  logic [q24_pkg::NumWidth:0] shifted;
  q24_pkg::lane_t lane_next;

  always_comb begin
    lane_next = lane_in;
    shifted = {lane_in.rem, lane_in.num[q24_pkg::NumWidth-1]};
    trial = shifted - {{(q24_pkg::NumWidth-q24_pkg::WordWidth+1){1'b0}}, lane_in.den};
    lane_next.num = {lane_in.num[q24_pkg::NumWidth-2:0], 1'b0};
    if (!trial[q24_pkg::NumWidth]) begin
      lane_next.rem = trial[q24_pkg::NumWidth-1:0];
      lane_next.num[0] = 1'b1;
    end else begin
      lane_next.rem = shifted[q24_pkg::NumWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (!stall) begin
      lane_out <= lane_next;
    end
  end

endmodule

// ----- rtl/q24_8_fixed_point_alu_unit.sv -----
// Pipeline: 1 decode register, 40 divider cells each retiring one quotient
// bit, 1 output register; the 64-bit product comes from one 32x32 multiply
// ahead of the first cell.
// Throughput: one item per cycle; the whole chain advances together and
// holds while the output register is full and not taken.
// Reset: synchronous, clears all valid flags; payload is not reset.
module q24_8_fixed_point_alu_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result[31:0], compare_true[32], divide_by_zero[33], pad
);

  localparam int W = q24_pkg::WordWidth;
  localparam int F = q24_pkg::FracBits;
  localparam int N = q24_pkg::NumWidth;
  localparam int C = q24_pkg::DivCells;

  logic stall;
  q24_pkg::lane_t chain [0:C];
  q24_pkg::lane_t dec;
  q24_pkg::lane_t head;
  logic [W-1:0] ma, mb;
  logic [3:0] func;
  logic signed [W-1:0] a, b;
  logic lt, gt;

  logic [2*W-1:0] mul_a, mul_b;

  logic out_valid;
  logic [W-1:0] out_res;
  logic out_cmp, out_dz;
  q24_pkg::lane_t fin;
  logic [W-1:0] fin_res;
  logic [2*W-1:0] prod_s;
  logic [N-1:0] quo_s;

  assign stall = out_valid && !m_tready;
  assign s_tready = !stall;

  assign func = s_tdata[3:0];
  assign a = s_tdata[4+W-1:4];
  assign b = s_tdata[4+2*W-1:4+W];
  assign ma = a[W-1] ? W'(-a) : a;
  assign mb = b[W-1] ? W'(-b) : b;
  assign lt = a < b;
  assign gt = b < a;

  always_comb begin
    dec = '0;
    dec.valid = s_tvalid;
    dec.side.neg = a[W-1] ^ b[W-1];
    dec.num = {ma, {F{1'b0}}};
    dec.den = mb;
    case (func)
      q24_pkg::OpAdd: dec.side.res = a + b;
      q24_pkg::OpSub: dec.side.res = a - b;
      q24_pkg::OpMul: begin
        dec.side.is_mul = 1'b1;
        dec.prod = {ma, mb};
      end
      q24_pkg::OpDiv: begin
        if (b == '0) dec.side.dz = 1'b1;
        else dec.side.is_div = 1'b1;
      end
      q24_pkg::OpGt: dec.side.cmp = gt;
      q24_pkg::OpLt: dec.side.cmp = lt;
      q24_pkg::OpGe: dec.side.cmp = !lt;
      q24_pkg::OpLe: dec.side.cmp = !gt;
      q24_pkg::OpEq: dec.side.cmp = a == b;
      q24_pkg::OpNe: dec.side.cmp = a != b;
      q24_pkg::OpMin: dec.side.res = lt ? a : b;
      q24_pkg::OpMax: dec.side.res = lt ? b : a;
      q24_pkg::OpInc: dec.side.res = a + W'(1);
      q24_pkg::OpDec: dec.side.res = a - W'(1);
      q24_pkg::OpFromInt: dec.side.res = a <<< F;
      q24_pkg::OpToInt: dec.side.res = a >>> F;
      default: dec.side.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (!stall) begin
      chain[0] <= dec;
    end
  end

  // multiply the operand magnitudes ahead of the first cell
  assign mul_a = {{W{1'b0}}, chain[0].prod[2*W-1:W]};
  assign mul_b = {{W{1'b0}}, chain[0].prod[W-1:0]};

  always_comb begin
    head = chain[0];
    head.prod = mul_a * mul_b;
  end

  for (genvar i = 0; i < C; i++) begin : g_cell
    q24_cell u_cell (
      .clk(clk), .rst(rst), .stall(stall), .lane_in((i == 0) ? head : chain[i]),
      .lane_out(chain[i+1])
    );
  end

  assign fin = chain[C];
  assign prod_s = fin.side.neg ? -fin.prod : fin.prod;
  assign quo_s = fin.side.neg ? -fin.num : fin.num;

  always_comb begin
    if (fin.side.is_mul) fin_res = prod_s[F+W-1:F];
    else if (fin.side.is_div) fin_res = quo_s[W-1:0];
    else fin_res = fin.side.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= fin.valid;
      out_res <= fin_res;
      out_cmp <= fin.side.cmp;
      out_dz <= fin.side.dz;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {6'b0, out_dz, out_cmp, out_res};

endmodule
